/* design/ppap_pkg.sv */
// ----------------------------------------------------------------------------
// ppap_pkg
// Types and codes shared by the polygon point/area/projection block.
// ----------------------------------------------------------------------------
package ppap_pkg;

	localparam int OP_BITS     = 3;
	localparam int AREA_BITS   = 39;
	localparam int PROJ_BITS   = 33;
	localparam int STATUS_BITS = 2;

	typedef enum logic [OP_BITS-1:0] {
		OP_PUSH  = 3'd0,
		OP_CLEAR = 3'd1,
		OP_POINT = 3'd2,
		OP_AREA  = 3'd3,
		OP_PROJ  = 3'd4
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch input word
		logic push;      // write vertex at count
		logic clear;     // zero count
		logic rd;        // issue store read at walk index
		logic walk_init; // reset walk index and accumulators
		logic acc;       // fold read vertex into accumulators
		logic finish;    // form result word
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       empty;
		logic       full;
		logic       rd_last;
		logic [OP_BITS-1:0] op;
	} ctl_sts_t;

endpackage

/* design/ppap_if.sv */
// ----------------------------------------------------------------------------
// ppap_in_if / ppap_out_if
// Valid/ready channels for input and result words.
// ----------------------------------------------------------------------------
interface ppap_in_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   op;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	modport source (output valid, op, coord_x, coord_y, input ready);
	modport sink (input valid, op, coord_x, coord_y, output ready);
endinterface

interface ppap_out_if;
	logic               valid;
	logic               ready;
	logic               inside_res;
	logic [38:0]        area_twice;
	logic signed [32:0] proj_min;
	logic signed [32:0] proj_max;
	logic [1:0]         status;
	modport source (output valid, inside_res, area_twice, proj_min, proj_max, status,
		input ready);
	modport sink (input valid, inside_res, area_twice, proj_min, proj_max, status,
		output ready);
endinterface

/* design/ppap_ctrl.sv */
// ----------------------------------------------------------------------------
// ppap_ctrl
// Sequencer: accept word, walk vertex store, emit result word.
// ----------------------------------------------------------------------------
module ppap_ctrl
	import ppap_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DEC  = 5'b00010,
		S_WALK = 5'b00100,
		S_DRAIN = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   acc_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.acc = acc_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.op == OP_PUSH) begin
					cmd.push   = ~sts.full;
					cmd.finish = 1'b1;
					state_d    = S_OUT;
				end else if (sts.op == OP_CLEAR || sts.empty ||
					!(sts.op == OP_POINT || sts.op == OP_AREA || sts.op == OP_PROJ)) begin
					cmd.clear  = (sts.op == OP_CLEAR);
					cmd.finish = 1'b1;
					state_d    = S_OUT;
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = S_WALK;
				end
			end
			S_WALK: begin
				cmd.rd = 1'b1;
				if (sts.rd_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!acc_q) begin
					cmd.finish = 1'b1;
					state_d    = S_OUT;
				end
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			acc_q   <= cmd.rd;
		end
	end

endmodule

/* design/ppap_dp.sv */
// ----------------------------------------------------------------------------
// ppap_dp
// Vertex store, walk counter, per-vertex multiply/accumulate and result word.
// ----------------------------------------------------------------------------
module ppap_dp
	import ppap_pkg::*;
#(
	parameter int MAX_VERTS  = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctl_cmd_t                     cmd,
	output ctl_sts_t                     sts,
	input  logic [OP_BITS-1:0]           in_op,
	input  logic signed [COORD_BITS-1:0] in_x,
	input  logic signed [COORD_BITS-1:0] in_y,
	output logic                         inside_res,
	output logic [AREA_BITS-1:0]         area_twice,
	output logic signed [PROJ_BITS-1:0]  proj_min,
	output logic signed [PROJ_BITS-1:0]  proj_max,
	output logic [STATUS_BITS-1:0]       status
);

	localparam int IDX_BITS = $clog2(MAX_VERTS);
	localparam int CNT_BITS = $clog2(MAX_VERTS + 1);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW + 1;
	localparam int SW = 2 * COORD_BITS + IDX_BITS + 2;
	localparam logic [CNT_BITS-1:0] MAXV = CNT_BITS'(MAX_VERTS);
	localparam logic signed [SW-1:0] PHI = SW'(64'sd4294967295);
	localparam logic signed [SW-1:0] PLO = -SW'(64'sd4294967296);
	localparam logic [SW-1:0] AMAX = SW'((65'd1 << AREA_BITS) - 65'd1);

	logic signed [COORD_BITS-1:0] mem_x [MAX_VERTS];
	logic signed [COORD_BITS-1:0] mem_y [MAX_VERTS];

	logic [CNT_BITS-1:0]          count_q;
	logic [OP_BITS-1:0]           op_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [CNT_BITS-1:0]          idx_q;
	logic signed [COORD_BITS-1:0] rx_q, ry_q;
	logic signed [COORD_BITS-1:0] fx_q, fy_q, qx_q, qy_q;
	logic                         first_q, hit_q, par_q, last_q;
	logic signed [SW-1:0]         sum_q, mn_q, mx_q;
	logic signed [PW-1:0]         m0, m1;
	logic signed [COORD_BITS-1:0] fxe, fye;

	assign sts.empty   = (count_q == '0);
	assign sts.full    = (count_q >= MAXV);
	assign sts.op      = op_q;
	assign sts.rd_last = (idx_q + CNT_BITS'(1) == count_q);

	// first vertex is the one being read while it is not yet latched
	assign fxe = first_q ? rx_q : fx_q;
	assign fye = first_q ? ry_q : fy_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_x[count_q[IDX_BITS-1:0]] <= px_q;
			mem_y[count_q[IDX_BITS-1:0]] <= py_q;
		end
		if (cmd.rd) begin
			rx_q <= mem_x[idx_q[IDX_BITS-1:0]];
			ry_q <= mem_y[idx_q[IDX_BITS-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cmd.clear) count_q <= '0;
		else if (cmd.push) count_q <= count_q + CNT_BITS'(1);
	end

	// edge from previous vertex q to current c (rx, ry)
	logic signed [DW-1:0] dxc, dyc, dqx, dqy, dpx, dpy, dfx, dfy;
	logic signed [PW:0]   s;
	logic                 straddle;
	always_comb begin
		dpx = DW'(px_q) - DW'(rx_q);
		dpy = DW'(py_q) - DW'(ry_q);
		dqx = DW'(qx_q) - DW'(rx_q);
		dqy = DW'(qy_q) - DW'(ry_q);
		dfx = DW'(fxe) - DW'(rx_q);
		dfy = DW'(fye) - DW'(ry_q);
		dxc = '0;
		dyc = '0;
		straddle = 1'b0;
		m0 = '0;
		m1 = '0;
		s  = '0;
		case (op_q)
			OP_POINT: begin
				m0 = PW'(dpx) * PW'(dqy);
				m1 = PW'(dqx) * PW'(dpy);
			end
			OP_AREA: begin
				m0 = PW'(qx_q) * PW'(ry_q);
				m1 = PW'(rx_q) * PW'(qy_q);
			end
			OP_PROJ: begin
				m0 = PW'(rx_q) * PW'(px_q);
				m1 = PW'(ry_q) * PW'(py_q);
			end
			default: ;
		endcase
		s = (PW+1)'(m0) - (PW+1)'(m1);
		straddle = (ry_q > py_q) != (qy_q > py_q);
		dxc = dfx;
		dyc = dfy;
	end

	// closing edge from last vertex to first
	logic signed [PW:0] sc, ac;
	logic               strc;
	always_comb begin
		sc = (PW+1)'(PW'(dpx) * PW'(dyc)) - (PW+1)'(PW'(dxc) * PW'(dpy));
		ac = (PW+1)'(PW'(rx_q) * PW'(fye)) - (PW+1)'(PW'(fxe) * PW'(ry_q));
		strc = (fye > py_q) != (ry_q > py_q);
	end

	logic signed [SW-1:0] sum_n, absum;
	logic                 par_n, hit_n;
	always_comb begin
		sum_n = sum_q;
		par_n = par_q;
		hit_n = hit_q;
		if (!first_q) begin
			sum_n = sum_q + SW'(s);
			if (straddle) begin
				if (s == '0) hit_n = 1'b1;
				else if ((s < 0) != (qy_q < ry_q)) par_n = ~par_n;
			end
		end
		if (px_q == rx_q && py_q == ry_q) hit_n = 1'b1;
		if (last_q) begin
			sum_n = sum_n + SW'(ac);
			if (strc) begin
				if (sc == '0) hit_n = 1'b1;
				else if ((sc < 0) != (fye < ry_q)) par_n = ~par_n;
			end
		end
		absum = (sum_q < 0) ? -sum_q : sum_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= in_op;
			px_q <= in_x;
			py_q <= in_y;
		end
		if (cmd.walk_init) begin
			idx_q   <= '0;
			first_q <= 1'b1;
			hit_q   <= 1'b0;
			par_q   <= 1'b0;
			sum_q   <= '0;
		end
		if (cmd.rd) begin
			idx_q  <= idx_q + CNT_BITS'(1);
			last_q <= sts.rd_last;
		end
		if (cmd.acc) begin
			first_q <= 1'b0;
			qx_q    <= rx_q;
			qy_q    <= ry_q;
			if (first_q) begin
				fx_q <= rx_q;
				fy_q <= ry_q;
			end
			if (op_q == OP_PROJ) begin
				if (first_q || SW'(m0) + SW'(m1) < mn_q) mn_q <= SW'(m0) + SW'(m1);
				if (first_q || SW'(m0) + SW'(m1) > mx_q) mx_q <= SW'(m0) + SW'(m1);
			end else begin
				sum_q <= sum_n;
				par_q <= par_n;
				hit_q <= hit_n;
			end
		end
		if (cmd.finish) begin
			inside_res <= 1'b0;
			area_twice <= '0;
			proj_min   <= '0;
			proj_max   <= '0;
			status     <= ST_OK;
			if (op_q == OP_PUSH) begin
				if (sts.full) status <= ST_FULL;
			end else if (op_q == OP_POINT || op_q == OP_AREA || op_q == OP_PROJ) begin
				if (sts.empty) status <= ST_EMPTY;
				else if (op_q == OP_POINT) inside_res <= hit_q | par_q;
				else if (op_q == OP_AREA)
					area_twice <= (absum > AMAX) ? AMAX[AREA_BITS-1:0] : absum[AREA_BITS-1:0];
				else begin
					proj_min <= (mn_q > PHI) ? PHI[PROJ_BITS-1:0] :
						(mn_q < PLO) ? PLO[PROJ_BITS-1:0] : mn_q[PROJ_BITS-1:0];
					proj_max <= (mx_q > PHI) ? PHI[PROJ_BITS-1:0] :
						(mx_q < PLO) ? PLO[PROJ_BITS-1:0] : mx_q[PROJ_BITS-1:0];
				end
			end
		end
	end

endmodule

/* design/polygon_point_area_projection.sv */
// ----------------------------------------------------------------------------
// polygon_point_area_projection
// Polygon vertex store with even-odd point test, shoelace area and
// axis projection.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   op, coord_x, coord_y
//  out_ch    out  inside_res, area_twice, proj_min, proj_max, status
//
//  Push, clear and empty queries go from S_IDLE through S_DEC to S_OUT.
//  Walk queries pass S_DEC, S_WALK and S_DRAIN, one store read per cycle (single read port).
//  One word in flight; in_ch ready again the cycle after the result is taken.
//  Reset zeroes the vertex count; store contents are not cleared.
// ----------------------------------------------------------------------------
module polygon_point_area_projection
	import ppap_pkg::*;
#(
	parameter int MAX_VERTS  = 64,
	parameter int COORD_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	ppap_in_if.sink    in_ch,
	ppap_out_if.source out_ch
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	ppap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ppap_dp #(
		.MAX_VERTS  (MAX_VERTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (in_ch.op),
		.in_x       (in_ch.coord_x),
		.in_y       (in_ch.coord_y),
		.inside_res (out_ch.inside_res),
		.area_twice (out_ch.area_twice),
		.proj_min   (out_ch.proj_min),
		.proj_max   (out_ch.proj_max),
		.status     (out_ch.status)
	);

endmodule
